FILE: hdl/assert_macros.svh
// Assertion macros shared by the integer-to-ASCII formatter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALW(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant failed");

`endif

FILE: hdl/iafmt_pkg.sv
// Shared types, constants and functions of the integer-to-ASCII formatter.
package iafmt_pkg;

   localparam int VALUE_W       = 64;
   localparam int DIGIT_W       = 4;
   localparam int NUM_DIGITS    = 20;
   localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(CONV_STEPS);
   localparam int POS_W         = $clog2(NUM_DIGITS);

   localparam logic [2:0] KIND_HEX_LO = 3'd0;
   localparam logic [2:0] KIND_HEX_UP = 3'd1;
   localparam logic [2:0] KIND_PTR    = 3'd2;
   localparam logic [2:0] KIND_SDEC   = 3'd3;
   localparam logic [2:0] KIND_UDEC   = 3'd4;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LOWA  = 8'h61;
   localparam logic [7:0] CH_UPA   = 8'h41;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_RPAR  = 8'h29;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_CONV,
      ST_PREFIX,
      ST_DIGITS
   } state_type;

   typedef enum logic [1:0] {
      PRE_NONE,
      PRE_MINUS,
      PRE_HEX,
      PRE_NIL
   } prefix_type;

   typedef struct packed {
      logic load;
      logic conv;
      logic pre_emit;
      logic dig_step;
   } cmd_type;

   typedef struct packed {
      logic       kind_ok;
      logic       is_dec;
      prefix_type pre_sel;
      logic       conv_done;
      logic       pre_last;
      logic       dig_last;
      logic       dig_visible;
      logic       out_free;
   } status_type;

endpackage

FILE: hdl/iafmt_req_if.sv
// Input channel of the formatter: valid/ready handshake with kind and value.
interface iafmt_req_if;
   import iafmt_pkg::*;

   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink (input valid, input kind, input value, output ready);
endinterface

// Result channel of the formatter: one character per transaction.
interface iafmt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink (input valid, input char_code, input last, output ready);
endinterface

FILE: hdl/iafmt_dpath.sv
// Datapath: value registers, binary-to-BCD converter, character select and output register.
module iafmt_dpath
   import iafmt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [2:0]         req_kind,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_char_code,
   output logic               rsp_last
);
`include "assert_macros.svh"

   logic [BCD_W-1:0]   digits_ff, digits_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [2:0]         pre_idx_ff, pre_idx_in;
   prefix_type         pre_sel_ff, pre_sel_in;
   logic               kind_ok_ff, kind_ok_in;
   logic               is_dec_ff, is_dec_in;
   logic               upper_ff, upper_in;
   logic               started_ff, started_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [BCD_W-1:0]   bcd_w;
   logic [VALUE_W-1:0] mag_w;
   logic [DIGIT_W-1:0] top_digit;
   logic               visible;
   logic               pre_last;
   logic               emit;
   logic               load_neg;
   logic [7:0]         digit_char;
   logic [7:0]         pre_char;

   // Adds three to every BCD digit of five or more before the next shift.
   function automatic logic [BCD_W-1:0] add3(input logic [BCD_W-1:0] bcd);
      logic [BCD_W-1:0] res;
      res = bcd;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            res[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
         end
      end
      return res;
   endfunction

   // Several double-dabble bit steps per cycle.
   always_comb begin
      bcd_w = digits_ff;
      mag_w = mag_ff;
      for (int b = 0; b < BITS_PER_STEP; b++) begin
         bcd_w = add3(bcd_w);
         bcd_w = {bcd_w[BCD_W-2:0], mag_w[VALUE_W-1]};
         mag_w = {mag_w[VALUE_W-2:0], 1'b0};
      end
   end

   assign top_digit = digits_ff[BCD_W-1 -: DIGIT_W];
   assign visible   = (top_digit != '0) || started_ff || (pos_ff == '0);

   always_comb begin
      unique case (pre_sel_ff)
         PRE_NIL:   pre_last = (pre_idx_ff == 3'd4);
         PRE_HEX:   pre_last = (pre_idx_ff == 3'd1);
         PRE_MINUS: pre_last = 1'b1;
         default:   pre_last = 1'b1;
      endcase
   end

   always_comb begin
      pre_char = CH_MINUS;
      unique case (pre_sel_ff)
         PRE_NIL: begin
            unique case (pre_idx_ff)
               3'd0:    pre_char = CH_LPAR;
               3'd1:    pre_char = CH_N;
               3'd2:    pre_char = CH_I;
               3'd3:    pre_char = CH_L;
               default: pre_char = CH_RPAR;
            endcase
         end
         PRE_HEX: pre_char = (pre_idx_ff == 3'd0) ? CH_ZERO : CH_X;
         default: pre_char = CH_MINUS;
      endcase
   end

   always_comb begin
      if (top_digit < 4'd10) begin
         digit_char = CH_ZERO + {4'b0, top_digit};
      end else begin
         digit_char = (upper_ff ? CH_UPA : CH_LOWA) + {4'b0, top_digit} - 8'd10;
      end
   end

   assign emit     = cmd.pre_emit || (cmd.dig_step && visible);
   assign load_neg = (req_kind == KIND_SDEC) && req_value[VALUE_W-1];

   always_comb begin
      digits_in  = digits_ff;
      mag_in     = mag_ff;
      step_in    = step_ff;
      pos_in     = pos_ff;
      pre_idx_in = pre_idx_ff;
      pre_sel_in = pre_sel_ff;
      kind_ok_in = kind_ok_ff;
      is_dec_in  = is_dec_ff;
      upper_in   = upper_ff;
      started_in = started_ff;

      if (cmd.load) begin
         kind_ok_in = (req_kind <= KIND_UDEC);
         is_dec_in  = (req_kind == KIND_SDEC) || (req_kind == KIND_UDEC);
         upper_in   = (req_kind == KIND_HEX_UP);
         step_in    = '0;
         pos_in     = POS_W'(NUM_DIGITS - 1);
         pre_idx_in = '0;
         started_in = 1'b0;
         if (req_kind == KIND_PTR) begin
            pre_sel_in = (req_value == '0) ? PRE_NIL : PRE_HEX;
         end else if (load_neg) begin
            pre_sel_in = PRE_MINUS;
         end else begin
            pre_sel_in = PRE_NONE;
         end
         // The magnitude of the most negative value is exact when read unsigned.
         if (req_kind == KIND_UDEC) begin
            mag_in = {{(VALUE_W-32){1'b0}}, req_value[31:0]};
         end else if (load_neg) begin
            mag_in = ~req_value + VALUE_W'(1);
         end else begin
            mag_in = req_value;
         end
         if ((req_kind == KIND_SDEC) || (req_kind == KIND_UDEC)) begin
            digits_in = '0;
         end else begin
            digits_in = {{(BCD_W-VALUE_W){1'b0}}, req_value};
         end
      end else if (cmd.conv) begin
         digits_in = bcd_w;
         mag_in    = mag_w;
         step_in   = step_ff + STEP_W'(1);
      end else if (cmd.pre_emit) begin
         pre_idx_in = pre_idx_ff + 3'd1;
      end else if (cmd.dig_step) begin
         digits_in  = {digits_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
         pos_in     = pos_ff - POS_W'(1);
         started_in = started_ff || visible;
      end
   end

   always_comb begin
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      if (cmd.pre_emit) begin
         rsp_char_in = pre_char;
         rsp_last_in = pre_last && (pre_sel_ff == PRE_NIL);
      end else if (emit) begin
         rsp_char_in = digit_char;
         rsp_last_in = (pos_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff   <= digits_in;
      mag_ff      <= mag_in;
      step_ff     <= step_in;
      pos_ff      <= pos_in;
      pre_idx_ff  <= pre_idx_in;
      pre_sel_ff  <= pre_sel_in;
      kind_ok_ff  <= kind_ok_in;
      is_dec_ff   <= is_dec_in;
      upper_ff    <= upper_in;
      started_ff  <= started_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.kind_ok     = kind_ok_ff;
   assign status.is_dec      = is_dec_ff;
   assign status.pre_sel     = pre_sel_ff;
   assign status.conv_done   = (step_ff == STEP_W'(CONV_STEPS - 1));
   assign status.pre_last    = pre_last;
   assign status.dig_last    = (pos_ff == '0);
   assign status.dig_visible = visible;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // A new character may only enter the output register once it is free.
   `ASSERT_IMP(a_emit_free, clock, reset, emit, !rsp_valid_ff || rsp_ready)
   // The final digit position is always printed, so the last flag is never lost.
   `ASSERT_IMP(a_last_visible, clock, reset, cmd.dig_step && (pos_ff == '0), visible)

endmodule

FILE: hdl/iafmt_ctrl.sv
// Controller: sequences decode, conversion, prefix and digit emission for each transaction.
module iafmt_ctrl
   import iafmt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
`include "assert_macros.svh"

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            // Undefined kinds produce no characters at all.
            priority if (!status.kind_ok) begin
               state_in = ST_IDLE;
            end else if (status.is_dec) begin
               state_in = ST_CONV;
            end else if (status.pre_sel != PRE_NONE) begin
               state_in = ST_PREFIX;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            if (status.conv_done) begin
               state_in = (status.pre_sel != PRE_NONE) ? ST_PREFIX : ST_DIGITS;
            end
         end
         ST_PREFIX: begin
            if (status.out_free) begin
               cmd.pre_emit = 1'b1;
               if (status.pre_last) begin
                  state_in = (status.pre_sel == PRE_NIL) ? ST_IDLE : ST_DIGITS;
               end
            end
         end
         ST_DIGITS: begin
            // Leading zeros are dropped without waiting on the output side.
            if (status.out_free || !status.dig_visible) begin
               cmd.dig_step = 1'b1;
               if (status.dig_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_ALW(a_cmd_onehot, clock, reset, $onehot0(cmd))
   `ASSERT_NXT(a_done_idle, clock, reset, cmd.dig_step && status.dig_last, state_ff == ST_IDLE)

endmodule

FILE: hdl/integer_to_ascii_formatter_top.sv
// Top level of the integer-to-ASCII formatter: controller, datapath and channel ports.
//
//   Channel  Dir  Fields                     Meaning
//   req_ch   in   kind[2:0], value[63:0]     one value and its format per transaction
//   rsp_ch   out  char_code[7:0], last       one ASCII character per transaction
//
// An item passes through an accept state and a decode state, then the conversion for
// decimal kinds (four bits per cycle through the BCD converter), the prefix characters
// and the 20 digit positions, one per BCD digit; a "(nil)" pointer returns to idle after
// its prefix, an undefined kind after decode. The next item is accepted while the last
// character still waits in the output register. A stalled output holds emission;
// synchronous reset clears the state machine and the output valid.
module integer_to_ascii_formatter_top
   import iafmt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   iafmt_req_if.sink   req_ch,
   iafmt_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   iafmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   iafmt_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_kind      (req_ch.kind),
      .req_value     (req_ch.value),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_char_code (rsp_ch.char_code),
      .rsp_last      (rsp_ch.last)
   );

   assign req_ch.ready = req_ready;

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the integer-to-ASCII formatter with random stalls.
module tb;
   import iafmt_pkg::*;

   typedef struct packed {
      logic [2:0]         kind;
      logic [VALUE_W-1:0] value;
   } fmt_item_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } fmt_char_type;

   typedef logic [7:0] char_q_type[$];

   // Kind codes above the unsigned decimal kind are undefined and must be dropped.
   localparam logic [2:0] KIND_FIRST_UNUSED = KIND_UDEC + 3'd1;
   localparam int         RANDOM_ITEMS      = 315;
   localparam int         DRAIN_CYCLES      = 100;
   localparam int         MAX_SHOWN         = 10;

   logic clock;
   logic reset;

   iafmt_req_if req_ch();
   iafmt_rsp_if rsp_ch();

   integer_to_ascii_formatter_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   fmt_item_type pending_items[$];
   fmt_char_type awaited_chars[$];
   fmt_item_type next_item;

   int items_offered  = 0;
   int items_accepted = 0;
   int ignored_kinds  = 0;
   int chars_taken    = 0;
   int chars_seen     = 0;
   int mismatch_count = 0;
   int send_wait      = 0;
   int take_wait      = 0;
   bit send_burst     = 0;
   bit take_burst     = 0;

   always #6 clock = ~clock;

   // Digits of v in the given radix, most significant first, no leading zeros.
   function automatic char_q_type digit_text(logic [VALUE_W-1:0] v,
                                             logic [VALUE_W-1:0] radix,
                                             logic [7:0] alpha);
      char_q_type         text;
      logic [VALUE_W-1:0] rem;
      logic [7:0]         ch;
      do begin
         rem = v % radix;
         if (rem < 10)
            ch = CH_ZERO + rem[7:0];
         else
            ch = alpha + rem[7:0] - 8'd10;
         text.push_front(ch);
         v = v / radix;
      end while (v != 0);
      return text;
   endfunction

   // Appends the characters that one accepted transaction should produce.
   function automatic void queue_text(logic [2:0] kind, logic [VALUE_W-1:0] value);
      char_q_type   text;
      fmt_char_type entry;
      case (kind)
         KIND_HEX_LO: text = digit_text(value, 64'd16, CH_LOWA);
         KIND_HEX_UP: text = digit_text(value, 64'd16, CH_UPA);
         KIND_PTR: begin
            if (value == 0) begin
               text = '{CH_LPAR, CH_N, CH_I, CH_L, CH_RPAR};
            end else begin
               text = digit_text(value, 64'd16, CH_LOWA);
               text.push_front(CH_X);
               text.push_front(CH_ZERO);
            end
         end
         KIND_SDEC: begin
            // The magnitude is taken as unsigned, so the most negative value needs no special path.
            if (value[VALUE_W-1]) begin
               text = digit_text(~value + 1'b1, 64'd10, CH_LOWA);
               text.push_front(CH_MINUS);
            end else begin
               text = digit_text(value, 64'd10, CH_LOWA);
            end
         end
         KIND_UDEC: text = digit_text({32'd0, value[31:0]}, 64'd10, CH_LOWA);
         default: text = {};
      endcase
      foreach (text[i]) begin
         entry.char_code = text[i];
         entry.last      = (i == text.size() - 1);
         awaited_chars.push_back(entry);
      end
   endfunction

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic void add_item(logic [2:0] kind, logic [VALUE_W-1:0] value);
      fmt_item_type item;
      item.kind  = kind;
      item.value = value;
      pending_items.push_back(item);
   endfunction

   // Driver: presents one transaction at a time and holds it until the monitor sees it taken.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (items_offered == items_accepted) begin
         if (send_wait > 0) begin
            send_wait--;
            req_ch.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            req_ch.kind  <= next_item.kind;
            req_ch.value <= next_item.value;
            req_ch.valid <= 1'b1;
            items_offered++;
            if ($urandom_range(0, 23) == 0)
               send_burst = !send_burst;
            send_wait = draw_wait(send_burst);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result side: after each taken character, ready drops for a randomly drawn stall, which may be zero.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (chars_taken != chars_seen) begin
            chars_seen = chars_taken;
            if ($urandom_range(0, 23) == 0)
               take_burst = !take_burst;
            take_wait = draw_wait(take_burst);
         end
         if (take_wait > 0) begin
            take_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Monitor and checker: both channels are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            queue_text(req_ch.kind, req_ch.value);
            items_accepted++;
            if (req_ch.kind > KIND_UDEC)
               ignored_kinds++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_chars.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN)
                  $display("unexpected character %h last=%b after %0d characters",
                           rsp_ch.char_code, rsp_ch.last, chars_taken);
            end else begin
               fmt_char_type want;
               want = awaited_chars.pop_front();
               if (want.char_code !== rsp_ch.char_code || want.last !== rsp_ch.last) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_SHOWN)
                     $display("character %0d: expected %h last=%b, got %h last=%b",
                              chars_taken, want.char_code, want.last,
                              rsp_ch.char_code, rsp_ch.last);
               end
            end
            chars_taken++;
         end
      end
   end

   initial begin
      int                 formatted;
      int                 pick;
      logic [2:0]         kind;
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] power;

      clock        = 1'b0;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind  = KIND_HEX_LO;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;

      // Zero in every kind, including the "(nil)" pointer.
      add_item(KIND_HEX_LO, 64'd0);
      add_item(KIND_HEX_UP, 64'd0);
      add_item(KIND_PTR, 64'd0);
      add_item(KIND_SDEC, 64'd0);
      add_item(KIND_UDEC, 64'd0);
      add_item(KIND_HEX_LO, 64'hFEDC_BA98_7654_3210);
      add_item(KIND_HEX_UP, 64'hFEDC_BA98_7654_3210);
      add_item(KIND_HEX_LO, '1);
      add_item(KIND_HEX_UP, 64'h0000_0000_0000_ABCD);
      add_item(KIND_PTR, 64'd1);
      add_item(KIND_PTR, '1);
      add_item(KIND_PTR, 64'h0000_7FFF_DEAD_BEEF);
      // The most negative value is the longest text the block can produce.
      add_item(KIND_SDEC, 64'h8000_0000_0000_0000);
      add_item(KIND_SDEC, 64'h7FFF_FFFF_FFFF_FFFF);
      add_item(KIND_SDEC, '1);
      add_item(KIND_SDEC, 64'd1);
      add_item(KIND_SDEC, 64'd1234567890);
      add_item(KIND_UDEC, 64'h0000_0000_FFFF_FFFF);
      add_item(KIND_UDEC, 64'hFFFF_FFFF_0000_0000);
      add_item(KIND_UDEC, 64'h1234_5678_0000_000A);
      add_item(KIND_UDEC, 64'd9);
      add_item(KIND_FIRST_UNUSED, 64'd5);
      add_item(KIND_FIRST_UNUSED + 3'd1, '1);
      add_item(KIND_FIRST_UNUSED + 3'd2, 64'd0);
      add_item(KIND_HEX_LO, 64'd10);

      formatted = 0;
      while (formatted < RANDOM_ITEMS) begin
         if ($urandom_range(0, 15) == 0) begin
            kind = KIND_FIRST_UNUSED + 3'($urandom_range(0, 2));
         end else begin
            kind = 3'($urandom_range(KIND_HEX_LO, KIND_UDEC));
            formatted++;
         end
         pick = $urandom_range(0, 19);
         if (pick < 5) begin
            value = {$urandom, $urandom};
         end else if (pick < 10) begin
            value = {$urandom, $urandom} >> $urandom_range(0, 63);
         end else if (pick < 13) begin
            value = -({$urandom, $urandom} >> $urandom_range(1, 63));
         end else if (pick < 16) begin
            value = $urandom_range(0, 20);
         end else if (pick < 18) begin
            // Powers of ten and their neighbors change the decimal digit count.
            power = 1;
            repeat ($urandom_range(0, 19)) power = power * 10;
            value = power - 1 + $urandom_range(0, 2);
            if ($urandom_range(0, 1) == 1)
               value = -value;
         end else begin
            case ($urandom_range(0, 4))
               0: value = '1;
               1: value = 64'h8000_0000_0000_0000;
               2: value = 64'h7FFF_FFFF_FFFF_FFFF;
               3: value = 64'h0000_0000_FFFF_FFFF;
               default: value = 64'h0000_0001_0000_0000;
            endcase
         end
         add_item(kind, value);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || items_offered != items_accepted)
         @(posedge clock);
      while (awaited_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Formatted %0d values across all five kinds, plus %0d with undefined kinds.",
               items_accepted - ignored_kinds, ignored_kinds);
      $display("Checked %0d characters, %0d mismatches.", chars_taken, mismatch_count);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #6000000;
      $display("Timed out with %0d characters still awaited.", awaited_chars.size());
      $display("FAILURE");
      $finish;
   end

endmodule
